FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion wrappers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// shared constants, codes and types of the bounded stack calculator
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int KIND_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int RESULT_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;
    localparam int CAP_W     = 5;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TOP     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ADD     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MUL     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESTART = 3'd5;

    // error states
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_DATA = 2'd2;

    typedef struct packed {
        logic wr;   // spill the second entry into the memory
        logic rd;   // refill the below-second register from the memory
        logic fwd;  // load the below-second register with the write data
    } t_mem_ctl;

    typedef struct packed {
        logic [RESULT_W-1:0] result;
        logic [STATUS_W-1:0] status;
        logic                refused;
        logic [FILL_W-1:0]   fill;
    } t_result;

endpackage

FILE: rtl/bsc_stack_mem.sv
// ----------------------------------------------------------------------------
// bsc_stack_mem
// storage for the entries below the top two, registered read
// ----------------------------------------------------------------------------
module bsc_stack_mem #(
    parameter int DEPTH     = bsc_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bsc_pkg::WORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  bsc_pkg::t_mem_ctl        i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WORD_BITS-1:0]     i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WORD_BITS-1:0]     o_rdata
);
    import bsc_pkg::*;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // a push moves the second entry down, so it is also the new third
        if (i_ctl.fwd) begin
            r_rdata <= i_wdata;
        end else if (i_ctl.rd) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bsc_core.sv
// ----------------------------------------------------------------------------
// bsc_core
// stack state and the combinational operation datapath
// ----------------------------------------------------------------------------
module bsc_core #(
    parameter int DEPTH     = bsc_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bsc_pkg::WORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  logic [bsc_pkg::KIND_W-1:0]       i_kind,
    input  logic [bsc_pkg::VALUE_W-1:0]      i_value,
    input  logic [bsc_pkg::CAP_W-1:0]        i_capacity,
    output bsc_pkg::t_result                 o_res,
    output logic [$clog2(DEPTH+1)-1:0]       o_count
);
    import bsc_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

    // top two entries and the bottom entry live in registers
    logic [WORD_BITS-1:0] r_top, n_top;
    logic [WORD_BITS-1:0] r_second, n_second;
    logic [WORD_BITS-1:0] r_bottom, n_bottom;
    logic [CW-1:0]        r_count, n_count;
    logic [STATUS_W-1:0]  r_err, n_err;

    logic [WORD_BITS-1:0] w_below;
    logic [WORD_BITS-1:0] w_val;
    logic [63:0]          w_val_ext;
    logic [WORD_BITS-1:0] w_sum;
    logic [WORD_BITS-1:0] w_prod;
    logic [WORD_BITS-1:0] w_arith;
    logic [WORD_BITS-1:0] w_res;
    logic [63:0]          w_res_ext;
    logic                 w_refused;
    logic                 w_full;
    t_mem_ctl             w_ctl;
    t_mem_ctl             w_ctl_gated;

    assign w_val_ext = {{(64 - VALUE_W){i_value[VALUE_W-1]}}, i_value};
    assign w_val     = w_val_ext[WORD_BITS-1:0];
    assign w_sum     = r_top + r_second;
    assign w_prod    = r_top * r_second;
    assign w_arith   = (i_kind == KIND_ADD) ? w_sum : w_prod;

    assign w_full = (CMP_W'(r_count) >= CMP_W'(i_capacity)) || (r_count == CW'(DEPTH));

    always_comb begin
        n_top     = r_top;
        n_second  = r_second;
        n_bottom  = r_bottom;
        n_count   = r_count;
        n_err     = r_err;
        w_res     = '0;
        w_refused = 1'b0;
        w_ctl     = '0;
        if (i_kind == KIND_RESTART) begin
            n_count = '0;
            n_err   = ST_OK;
        end else if (i_kind <= KIND_MUL && r_err != ST_OK) begin
            // sticky error: state holds
            w_refused = 1'b1;
            case (i_kind) inside
                KIND_POP, KIND_TOP: w_res = r_bottom;
                KIND_ADD:           w_res = '1;
                default:            w_res = '0;
            endcase
        end else begin
            case (i_kind) inside
                KIND_PUSH: begin
                    if (w_full) begin
                        n_err = ST_FULL;
                    end else begin
                        n_top     = w_val;
                        n_second  = r_top;
                        w_ctl.fwd = 1'b1;
                        w_ctl.wr  = (r_count >= CW'(2));
                        if (r_count == '0) begin
                            n_bottom = w_val;
                        end
                        n_count = r_count + CW'(1);
                    end
                end
                KIND_POP, KIND_TOP: begin
                    if (r_count == '0) begin
                        n_err = ST_NO_DATA;
                    end else begin
                        w_res = r_top;
                        if (i_kind == KIND_POP) begin
                            n_top    = r_second;
                            n_second = w_below;
                            w_ctl.rd = 1'b1;
                            n_count  = r_count - CW'(1);
                        end
                    end
                end
                KIND_ADD, KIND_MUL: begin
                    if (r_count <= CW'(1)) begin
                        n_err = ST_NO_DATA;
                    end else begin
                        w_res    = w_arith;
                        n_top    = w_arith;
                        n_second = w_below;
                        w_ctl.rd = 1'b1;
                        if (r_count == CW'(2)) begin
                            n_bottom = w_arith;
                        end
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_ctl_gated = i_fire ? w_ctl : '0;

    bsc_stack_mem #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl_gated),
        .i_waddr (AW'(r_count - CW'(2))),
        .i_wdata (r_second),
        .i_raddr (AW'(r_count - CW'(4))),
        .o_rdata (w_below)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_err   <= ST_OK;
        end else if (i_fire) begin
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_top    <= n_top;
            r_second <= n_second;
            r_bottom <= n_bottom;
        end
    end

    assign w_res_ext      = 64'(w_res);
    assign o_res.result   = w_res_ext[RESULT_W-1:0];
    assign o_res.status   = n_err;
    assign o_res.refused  = w_refused;
    assign o_res.fill     = FILL_W'(n_count);
    assign o_count        = r_count;

endmodule

FILE: rtl/bounded_stack_calculator_top.sv
// ----------------------------------------------------------------------------
// bounded_stack_calculator_top
// bounded stack of signed words with push, pop, top, add, multiply, restart
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  --------+-----------+------------------------------------------------------
//  s       | in        | i_s_tvalid, o_s_tready, i_s_tdata, i_s_tuser
//  m       | out       | o_m_tvalid, i_m_tready, o_m_tdata, o_m_tuser
//  cfg     | in        | i_cfg_valid, o_cfg_ready, i_cfg_data
//
//  one item per cycle sustained while the receiver keeps up; result registered
//  after acceptance (input register, then result register), the operation
//  is combinational between them on the top-two registers and
//  a prefetched third entry; reset clears count, error and capacity (16);
//  entries are not cleared; a stalled result holds in the output register, the
//  input register backs up behind it and then tready drops
// ----------------------------------------------------------------------------
module bounded_stack_calculator_top #(
    parameter int DEPTH     = bsc_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bsc_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [31:0]                 i_s_tdata,   // value[31:0]
    input  logic [2:0]                  i_s_tuser,   // kind[2:0]
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [39:0]                 o_m_tdata,   // result[31:0], fill[36:32], zero
    output logic [2:0]                  o_m_tuser,   // status[1:0], refused[2]
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bsc_pkg::CAP_W-1:0]   i_cfg_data
);
    import bsc_pkg::*;

    `include "assert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);

    logic                r_in_valid;
    logic [KIND_W-1:0]   r_in_kind;
    logic [VALUE_W-1:0]  r_in_value;
    logic                r_out_valid;
    t_result             r_out;
    logic [CAP_W-1:0]    r_capacity;

    logic                w_adv;
    t_result             w_res;
    logic [CW-1:0]       w_count;
    logic                w_step_op;
    logic [CW-1:0]       w_count_up;

    assign w_adv       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= CAP_RESET;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_kind  <= i_s_tuser;
            r_in_value <= i_s_tdata;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    bsc_core #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_adv),
        .i_kind     (r_in_kind),
        .i_value    (r_in_value),
        .i_capacity (r_capacity),
        .o_res      (w_res),
        .o_count    (w_count)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.fill, r_out.result};
    assign o_m_tuser  = {r_out.refused, r_out.status};

    // an item other than restart moves the count by at most one
    assign w_step_op  = w_adv && (r_in_kind != KIND_RESTART);
    assign w_count_up = w_count + CW'(1);

    `ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_m_tvalid && !r_in_valid, "not idle after reset")
    `ASSERT_CLK(a_refused_err, o_m_tvalid && r_out.refused |-> r_out.status != ST_OK, "bad refused")
    `ASSERT_CLK(a_count_step, w_step_op |=> w_count_up - $past(w_count) <= CW'(2), "count jump")
    `ASSERT_CLK(a_fill_bound, w_count <= CW'(DEPTH), "count beyond depth")

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the bounded stack calculator item by item against an internal
// stack predictor: a table of directed operations after reset, then random
// phases over several capacities and idling mixes, and one long receiver
// hold-off that backs the block up until it drops its input ready
// ----------------------------------------------------------------------------
module tb_top;
    import bsc_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int PHASE_ITEMS  = 215;
    localparam int HOLD_CYCLES  = 64;

    // kinds with no operation behind them
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    localparam logic [KIND_W-1:0] STACK_OPS [0:4] =
        '{KIND_PUSH, KIND_POP, KIND_TOP, KIND_ADD, KIND_MUL};

    localparam logic [CAP_W-1:0] PHASE_CAPS [0:7] =
        '{5'd1, 5'd31, 5'd0, 5'd3, 5'd16, 5'd2, 5'd8, 5'd17};

    typedef struct packed {
        logic [KIND_W-1:0]   op;
        logic [VALUE_W-1:0]  word;
        logic                typed;
        logic [RESULT_W-1:0] res;
        logic [STATUS_W-1:0] st;
        logic                refused;
        logic [FILL_W-1:0]   fill;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TABLE [0:DIR_ROWS-1] = '{
        '{KIND_TOP,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_NO_DATA, 1'b0, 5'd0},
        '{KIND_RESTART, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,      1'b0, 5'd0},
        '{KIND_PUSH,    32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_OK,      1'b0, 5'd1},
        '{KIND_PUSH,    32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK,      1'b0, 5'd2},
        '{KIND_TOP,     32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK,      1'b0, 5'd2},
        '{KIND_ADD,     32'h0000_0000, 1'b1, 32'hffff_ffff, ST_OK,      1'b0, 5'd1},
        '{KIND_PUSH,    32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK,      1'b0, 5'd2},
        '{KIND_MUL,     32'h0000_0000, 1'b1, 32'h0000_0001, ST_OK,      1'b0, 5'd1},
        '{KIND_PUSH,    32'h8000_0000, 1'b0, 32'h0000_0000, ST_OK,      1'b0, 5'd0},
        '{KIND_PUSH,    32'h8000_0000, 1'b0, 32'h0000_0000, ST_OK,      1'b0, 5'd0},
        '{KIND_MUL,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      1'b0, 5'd0},
        '{KIND_ADD,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      1'b0, 5'd0},
        '{KIND_POP,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      1'b0, 5'd0},
        '{KIND_ADD,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_NO_DATA, 1'b0, 5'd0},
        '{KIND_POP,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      1'b0, 5'd0},
        '{KIND_ADD,     32'h0000_0000, 1'b1, 32'hffff_ffff, ST_NO_DATA, 1'b1, 5'd0},
        '{KIND_MUL,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_NO_DATA, 1'b1, 5'd0},
        '{KIND_PUSH,    32'h1234_5678, 1'b1, 32'h0000_0000, ST_NO_DATA, 1'b1, 5'd0},
        '{KIND_TOP,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      1'b0, 5'd0},
        '{KIND_SPARE_A, 32'hdead_beef, 1'b1, 32'h0000_0000, ST_NO_DATA, 1'b0, 5'd0},
        '{KIND_RESTART, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,      1'b0, 5'd0},
        '{KIND_PUSH,    32'h0000_0005, 1'b1, 32'h0000_0000, ST_OK,      1'b0, 5'd1},
        '{KIND_MUL,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_NO_DATA, 1'b0, 5'd1},
        '{KIND_SPARE_B, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_NO_DATA, 1'b0, 5'd1},
        '{KIND_RESTART, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,      1'b0, 5'd0}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [31:0]          i_s_tdata   = '0;
    logic [2:0]           i_s_tuser   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [39:0]          o_m_tdata;
    logic [2:0]           o_m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CAP_W-1:0]     i_cfg_data  = '0;

    // predicted stack contents and registers
    logic [RESULT_W-1:0]  stk_words [0:DEPTH_DEF-1];
    int unsigned          stk_fill   = 0;
    logic [STATUS_W-1:0]  stk_err    = ST_OK;
    logic [CAP_W-1:0]     stk_cap    = CAP_RESET;
    bit                   bottom_ok  = 1'b0;

    t_result              expected_q [$];
    t_result              got_r;
    t_result              want_r;
    int                   mismatch_cnt = 0;
    int                   cycle_cnt    = 0;
    int                   tx_idle_pct  = 0;
    int                   rx_stall_pct = 0;
    logic                 long_hold    = 1'b0;
    int                   hold_cnt     = 0;

    bounded_stack_calculator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: one long hold-off when asked, random stalls otherwise
    always @(posedge i_clk) begin
        if (long_hold && hold_cnt < HOLD_CYCLES) begin
            i_m_tready <= 1'b0;
            hold_cnt   <= hold_cnt + 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_cnt < 50)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_cnt, what, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_r = '{o_m_tdata[31:0], o_m_tuser[1:0], o_m_tuser[2], o_m_tdata[36:32]};
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item", got_r.result, '0);
            end else begin
                want_r = expected_q.pop_front();
                if (got_r.result !== want_r.result)
                    report_mismatch("result", got_r.result, want_r.result);
                if (got_r.status !== want_r.status)
                    report_mismatch("status", got_r.status, want_r.status);
                if (got_r.refused !== want_r.refused)
                    report_mismatch("refused", got_r.refused, want_r.refused);
                if (got_r.fill !== want_r.fill)
                    report_mismatch("fill", got_r.fill, want_r.fill);
            end
        end
    end

    // applies one operation to the predicted stack and returns its result
    function automatic t_result stack_step(input logic [KIND_W-1:0] op,
                                           input logic [VALUE_W-1:0] word);
        t_result     r;
        int unsigned room;
        logic [RESULT_W-1:0] a;
        logic [RESULT_W-1:0] b;
        r    = '0;
        room = (stk_cap > DEPTH_DEF) ? DEPTH_DEF : stk_cap;
        if (op == KIND_RESTART) begin
            stk_fill = 0;
            stk_err  = ST_OK;
        end else if (op <= KIND_MUL && stk_err != ST_OK) begin
            r.refused = 1'b1;
            if (op == KIND_POP || op == KIND_TOP)
                r.result = stk_words[0];
            else if (op == KIND_ADD)
                r.result = '1;
        end else if (op == KIND_PUSH) begin
            if (stk_fill >= room) begin
                stk_err = ST_FULL;
            end else begin
                stk_words[stk_fill] = word;
                if (stk_fill == 0)
                    bottom_ok = 1'b1;
                stk_fill++;
            end
        end else if (op == KIND_POP || op == KIND_TOP) begin
            if (stk_fill == 0) begin
                stk_err = ST_NO_DATA;
            end else begin
                r.result = stk_words[stk_fill-1];
                if (op == KIND_POP)
                    stk_fill--;
            end
        end else if (op == KIND_ADD || op == KIND_MUL) begin
            if (stk_fill <= 1) begin
                stk_err = ST_NO_DATA;
            end else begin
                a = stk_words[stk_fill-1];
                b = stk_words[stk_fill-2];
                r.result = (op == KIND_ADD) ? a + b : a * b;
                stk_words[stk_fill-2] = r.result;
                if (stk_fill == 2)
                    bottom_ok = 1'b1;
                stk_fill--;
            end
        end
        r.status = stk_err;
        r.fill   = stk_fill[FILL_W-1:0];
        return r;
    endfunction

    // mostly well-formed use; a stuck error is usually cleared by a restart
    function automatic logic [KIND_W-1:0] pick_op();
        int unsigned         r;
        logic [KIND_W-1:0]   op;
        r = $urandom_range(99);
        if (stk_err != ST_OK) begin
            if (r < 50)
                op = KIND_RESTART;
            else if (r < 58)
                op = r[0] ? KIND_SPARE_A : KIND_SPARE_B;
            else
                op = STACK_OPS[$urandom_range(4)];
        end else begin
            if (r < 45)      op = KIND_PUSH;
            else if (r < 58) op = KIND_POP;
            else if (r < 67) op = KIND_TOP;
            else if (r < 78) op = KIND_ADD;
            else if (r < 89) op = KIND_MUL;
            else if (r < 94) op = KIND_RESTART;
            else             op = r[0] ? KIND_SPARE_A : KIND_SPARE_B;
        end
        // a refused read returns the bottom entry, which must have been written
        if (stk_err != ST_OK && !bottom_ok && (op == KIND_POP || op == KIND_TOP))
            op = KIND_RESTART;
        return op;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_word();
        logic [VALUE_W-1:0] w;
        case ($urandom_range(3))
            0: w = $urandom_range(20) - 10;
            1: begin
                case ($urandom_range(3))
                    0: w = 32'h8000_0000;
                    1: w = 32'h7fff_ffff;
                    2: w = 32'hffff_ffff;
                    default: w = 32'h0000_0000;
                endcase
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic send_op(input logic [KIND_W-1:0] op, input logic [VALUE_W-1:0] word,
                           input bit use_typed, input t_result typed);
        int      gap;
        t_result calc;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        calc = stack_step(op, word);
        expected_q.push_back(use_typed ? typed : calc);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        stk_cap = cap;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
            1: begin tx_idle_pct = 58; rx_stall_pct <= 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct <= 58; end
            default: begin tx_idle_pct = 29; rx_stall_pct <= 29; end
        endcase
    endtask

    initial begin
        t_dir_row row;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIR_TABLE[i];
            send_op(row.op, row.word, row.typed,
                    '{row.res, row.st, row.refused, row.fill});
        end

        for (int p = 0; p < 8; p++) begin
            set_idling(p % 4);
            write_capacity(PHASE_CAPS[p]);
            repeat (PHASE_ITEMS) send_op(pick_op(), pick_word(), 1'b0, '0);
        end

        // sender keeps offering while the receiver holds off
        set_idling(0);
        write_capacity(CAP_RESET);
        long_hold <= 1'b1;
        repeat (40) send_op(pick_op(), pick_word(), 1'b0, '0);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bsc_pkg.sv
rtl/bsc_stack_mem.sv
rtl/bsc_core.sv
rtl/bounded_stack_calculator_top.sv
test/tb_top.sv
